// ----- rtl/preroll_frame_ring_manager_core_assert.svh -----
// assertion macros shared by the preroll frame ring manager modules
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef PREROLL_FRAME_RING_MANAGER_CORE_ASSERT_SVH
`define PREROLL_FRAME_RING_MANAGER_CORE_ASSERT_SVH

// condition holds at every clock edge outside reset
`define PFRM_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define PFRM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pfrm_pkg.sv -----
// shared types and constants of the preroll frame ring manager
// no dependencies; used by the controller, the datapath and the top level
package pfrm_pkg;

    // field widths of the stream items
    localparam int FUNC_W     = 2;
    localparam int LEN_W      = 20;
    localparam int MS_W       = 32;
    localparam int OUT_OFF_W  = 20;
    localparam int OUT_CNT_W  = 8;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 88;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH  = 2'd0,
        FUNC_POP   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    // register indexes
    localparam logic REG_KEEP_MS = 1'b0;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_COMMIT,
        ST_POP_WAIT,
        ST_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic scan_start;
        logic scan;
        logic commit;
        logic pop_issue;
        logic pop_capture;
        logic other_done;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic push_ok;
        logic pop_ok;
        logic scan_done;
        logic out_busy;
    } sts_t;

endpackage

// ----- rtl/pfrm_datapath.sv -----
// datapath: descriptor memory, ring pointers, scan pipeline and result registers
// depends on pfrm_pkg and the assertion macro header
`include "preroll_frame_ring_manager_core_assert.svh"

module pfrm_datapath #(
    parameter int BUFFER_BYTES = 786432,
    parameter int MAX_ENTRIES  = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pfrm_pkg::cmd_t                    cmd,
    output pfrm_pkg::sts_t                    sts,
    input  logic [pfrm_pkg::FUNC_W-1:0]       in_func,
    input  logic [pfrm_pkg::LEN_W-1:0]        in_len,
    input  logic [pfrm_pkg::MS_W-1:0]         in_ms,
    input  logic [pfrm_pkg::MS_W-1:0]         keep_ms,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic                              out_accepted,
    output logic [pfrm_pkg::OUT_OFF_W-1:0]    out_offset,
    output logic [pfrm_pkg::LEN_W-1:0]        out_entry_len,
    output logic [pfrm_pkg::MS_W-1:0]         out_entry_ms,
    output logic [pfrm_pkg::OUT_CNT_W-1:0]    out_dropped,
    output logic [pfrm_pkg::OUT_CNT_W-1:0]    out_count
);
    import pfrm_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int SW    = IDX_W + 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int OFF_W = $clog2(BUFFER_BYTES + 1);
    localparam int SUM_W = ((OFF_W > LEN_W) ? OFF_W : LEN_W) + 1;
    localparam int HALF  = BUFFER_BYTES / 2;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [MS_W-1:0]  ms;
    } ent_t;

    // descriptor memory, no reset
    ent_t mem [MAX_ENTRIES];
    ent_t rd_data_reg;

    logic [FUNC_W-1:0] func_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [OFF_W-1:0]  wp_reg;
    logic [CNT_W-1:0]  rd_k_reg;
    logic [CNT_W-1:0]  chk_k_reg;
    logic              chk_valid_reg;
    logic              prefix_reg;
    logic [CNT_W-1:0]  age_n_reg;
    logic [CNT_W-1:0]  ov_end_reg;

    logic                 res_acc_reg;
    logic [OFF_W-1:0]     res_off_reg;
    logic [LEN_W-1:0]     res_len_reg;
    logic [MS_W-1:0]      res_ms_reg;
    logic [CNT_W-1:0]     res_drop_reg;
    logic [CNT_W-1:0]     res_cnt_reg;

    logic                 m_valid_reg;
    logic                 m_acc_reg;
    logic [OFF_W-1:0]     m_off_reg;
    logic [LEN_W-1:0]     m_len_reg;
    logic [MS_W-1:0]      m_ms_reg;
    logic [CNT_W-1:0]     m_drop_reg;
    logic [CNT_W-1:0]     m_cnt_reg;

    logic              issue;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [SW-1:0]     scan_sum;
    logic [SW-1:0]     head_drop_sum;
    logic [SW-1:0]     tail_sum;
    logic [IDX_W-1:0]  scan_slot;
    logic [IDX_W-1:0]  head_after_drop;
    logic [IDX_W-1:0]  tail_slot;
    logic [IDX_W-1:0]  head_plus_one;
    logic [CNT_W-1:0]  drop_max;
    logic [CNT_W-1:0]  drop_n;
    logic [MS_W-1:0]   age;
    logic              expired;
    logic              overlap;
    logic [SUM_W-1:0]  new_end;
    logic [SUM_W-1:0]  ent_end;
    logic              wrap;

    // ring index arithmetic with one compare and subtract
    always_comb begin
        scan_sum      = SW'(head_reg) + SW'(rd_k_reg);
        head_drop_sum = SW'(head_reg) + SW'(drop_n);
        tail_sum      = SW'(head_reg) + SW'(count_reg);
        scan_slot       = IDX_W'((scan_sum >= SW'(MAX_ENTRIES)) ?
                                 scan_sum - SW'(MAX_ENTRIES) : scan_sum);
        head_after_drop = IDX_W'((head_drop_sum >= SW'(MAX_ENTRIES)) ?
                                 head_drop_sum - SW'(MAX_ENTRIES) : head_drop_sum);
        tail_slot       = IDX_W'((tail_sum >= SW'(MAX_ENTRIES)) ?
                                 tail_sum - SW'(MAX_ENTRIES) : tail_sum);
        head_plus_one   = (head_reg == IDX_W'(MAX_ENTRIES - 1)) ? '0 : head_reg + 1'b1;
    end

    // drop count: expired prefix, newest overlapping entry, or one for a full table
    always_comb begin
        drop_max = (age_n_reg > ov_end_reg) ? age_n_reg : ov_end_reg;
        if ((drop_max == '0) && (count_reg == CNT_W'(MAX_ENTRIES))) begin
            drop_n = CNT_W'(1);
        end else begin
            drop_n = drop_max;
        end
    end

    // age and overlap test of the entry in the check stage
    always_comb begin
        age     = ms_reg - rd_data_reg.ms;
        expired = age > keep_ms;
        new_end = SUM_W'(wp_reg) + SUM_W'(len_reg);
        ent_end = SUM_W'(rd_data_reg.off) + SUM_W'(rd_data_reg.len);
        overlap = (SUM_W'(rd_data_reg.off) < new_end) && (SUM_W'(wp_reg) < ent_end);
        wrap    = new_end > SUM_W'(BUFFER_BYTES);
    end

    // read port select
    always_comb begin
        issue   = cmd.scan && (rd_k_reg < count_reg);
        rd_en   = issue || cmd.pop_issue;
        rd_addr = cmd.pop_issue ? head_reg : scan_slot;
    end

    // memory write on commit, registered read
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            mem[tail_slot] <= '{off: wp_reg, len: len_reg, ms: ms_reg};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // latched item and scan accumulators
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            func_reg <= in_func;
            len_reg  <= in_len;
            ms_reg   <= in_ms;
        end
        if (cmd.scan_start) begin
            prefix_reg <= 1'b1;
            age_n_reg  <= '0;
            ov_end_reg <= '0;
        end else if (chk_valid_reg) begin
            if (prefix_reg && expired) begin
                age_n_reg <= chk_k_reg + 1'b1;
            end else begin
                prefix_reg <= 1'b0;
                if (overlap) begin
                    ov_end_reg <= chk_k_reg + 1'b1;
                end
            end
        end
        chk_k_reg <= rd_k_reg;
    end

    // ring state and scan control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            count_reg     <= '0;
            wp_reg        <= '0;
            rd_k_reg      <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            chk_valid_reg <= issue;
            if (cmd.scan_start) begin
                rd_k_reg <= '0;
                if (wrap) begin
                    wp_reg <= '0;
                end
            end else if (issue) begin
                rd_k_reg <= rd_k_reg + 1'b1;
            end
            if (cmd.commit) begin
                head_reg  <= head_after_drop;
                count_reg <= count_reg - drop_n + 1'b1;
                wp_reg    <= OFF_W'(new_end);
            end
            if (cmd.pop_capture) begin
                head_reg  <= head_plus_one;
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.other_done && (func_reg == FUNC_CLEAR)) begin
                head_reg  <= '0;
                count_reg <= '0;
                wp_reg    <= '0;
            end
        end
    end

    // result of the current item
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            res_acc_reg  <= 1'b1;
            res_off_reg  <= wp_reg;
            res_len_reg  <= len_reg;
            res_ms_reg   <= ms_reg;
            res_drop_reg <= drop_n;
            res_cnt_reg  <= count_reg - drop_n + 1'b1;
        end else if (cmd.pop_capture) begin
            res_acc_reg  <= 1'b1;
            res_off_reg  <= rd_data_reg.off;
            res_len_reg  <= rd_data_reg.len;
            res_ms_reg   <= rd_data_reg.ms;
            res_drop_reg <= '0;
            res_cnt_reg  <= count_reg - 1'b1;
        end else if (cmd.other_done) begin
            res_acc_reg  <= 1'b0;
            res_off_reg  <= '0;
            res_len_reg  <= (func_reg == FUNC_PUSH) ? len_reg : '0;
            res_ms_reg   <= (func_reg == FUNC_PUSH) ? ms_reg : '0;
            res_drop_reg <= '0;
            res_cnt_reg  <= (func_reg == FUNC_CLEAR) ? '0 : count_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_acc_reg  <= res_acc_reg;
            m_off_reg  <= res_off_reg;
            m_len_reg  <= res_len_reg;
            m_ms_reg   <= res_ms_reg;
            m_drop_reg <= res_drop_reg;
            m_cnt_reg  <= res_cnt_reg;
        end
    end

    // status back to the controller
    always_comb begin
        sts.push_ok   = (func_reg == FUNC_PUSH) && (len_reg <= LEN_W'(HALF));
        sts.pop_ok    = (func_reg == FUNC_POP) && (count_reg != '0);
        sts.scan_done = (rd_k_reg == count_reg) && !chk_valid_reg;
        sts.out_busy  = m_valid_reg && !out_ready;
    end

    assign out_valid     = m_valid_reg;
    assign out_accepted  = m_acc_reg;
    assign out_offset    = OUT_OFF_W'(m_off_reg);
    assign out_entry_len = m_len_reg;
    assign out_entry_ms  = m_ms_reg;
    assign out_dropped   = OUT_CNT_W'(m_drop_reg);
    assign out_count     = OUT_CNT_W'(m_cnt_reg);

    // checks
    `PFRM_ASSERT_HOLDS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(MAX_ENTRIES),
        "entry count above table size")
    `PFRM_ASSERT_HOLDS(a_wp_bound, aclk, aresetn, wp_reg <= OFF_W'(BUFFER_BYTES),
        "write pointer past buffer end")
    `PFRM_ASSERT_NEXT(a_commit_count, aclk, aresetn, cmd.commit, count_reg != '0,
        "ring empty after a stored push")
    `PFRM_ASSERT_IMPL(a_check_in_scan, aclk, aresetn, chk_valid_reg, cmd.scan,
        "scan check stage active outside scan")

endmodule

// ----- rtl/pfrm_ctrl.sv -----
// controller state machine sequencing accept, scan, commit, pop and result hand-off
// depends on pfrm_pkg and the assertion macro header
`include "preroll_frame_ring_manager_core_assert.svh"

module pfrm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pfrm_pkg::sts_t sts,
    output pfrm_pkg::cmd_t cmd
);
    import pfrm_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.push_ok) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else if (sts.pop_ok) begin
                    cmd.pop_issue = 1'b1;
                    state_next    = ST_POP_WAIT;
                end else begin
                    cmd.other_done = 1'b1;
                    state_next     = ST_RESP;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_RESP;
            end
            ST_POP_WAIT: begin
                cmd.pop_capture = 1'b1;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // checks
    `PFRM_ASSERT_NEXT(a_accept_exec, aclk, aresetn, in_valid && in_ready,
        state_reg == ST_EXEC, "accepted beat not executed")
    `PFRM_ASSERT_NEXT(a_scan_commit, aclk, aresetn, (state_reg == ST_SCAN) && sts.scan_done,
        state_reg == ST_COMMIT, "finished scan not committed")
    `PFRM_ASSERT_IMPL(a_load_free, aclk, aresetn, cmd.load_out, !sts.out_busy,
        "result loaded over a waiting beat")

endmodule

// ----- rtl/preroll_frame_ring_manager_core.sv -----
// top level of the preroll frame ring manager: stream ports, register port
// depends on pfrm_pkg, pfrm_ctrl and pfrm_datapath
//
// Keeps offset, length and timestamp descriptors of frames in a circular byte
// buffer. One beat on the s_ channel is one command (tuser: push, pop, clear);
// each command returns exactly one beat on the m_ channel.
// A push drops entries older than keep_ms, wraps the write pointer to zero
// when the frame would run past the buffer end, drops the oldest entries
// until none overlaps the new range and the table has room, then stores it.
// A push runs the descriptor scan, which reads one memory entry per cycle over
// the stored entries, then commits and returns its result; a pop reads the
// head entry and returns it; clear and rejected commands skip both steps.
// One command is in flight at a time; the next beat is taken once the result
// sits in the output register, even while the receiver has not taken it.
// If m_tready stays low the result holds and the block waits before handing
// over the next result. keep_ms must be written through the register port at
// address 0 while no command is in flight; the block does not enforce this.
// Reset (aresetn low, synchronous) empties the ring, zeroes the write pointer
// and keep_ms; descriptor memory is not cleared and needs no clearing pass.
module preroll_frame_ring_manager_core #(
    parameter int BUFFER_BYTES = 786432,
    parameter int MAX_ENTRIES  = 128
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input commands
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pfrm_pkg::S_TDATA_W-1:0]      s_tdata,  // frame_len[19:0], time_ms[51:20]
    input  logic [pfrm_pkg::FUNC_W-1:0]         s_tuser,  // func[1:0]
    // results
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pfrm_pkg::M_TDATA_W-1:0]      m_tdata,  // offset[19:0], entry_len[39:20],
                                                          // entry_ms[71:40], dropped[79:72],
                                                          // count[87:80]
    output logic                                m_tuser,  // accepted[0]
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pfrm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pfrm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pfrm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import pfrm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [MS_W-1:0]      keep_reg;
    logic                 out_acc;
    logic [OUT_OFF_W-1:0] out_off;
    logic [LEN_W-1:0]     out_len;
    logic [MS_W-1:0]      out_ms;
    logic [OUT_CNT_W-1:0] out_drop;
    logic [OUT_CNT_W-1:0] out_cnt;
    logic                 cfg_we;

    // register port, writes complete in the access cycle
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_KEEP_MS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= '0;
        end else if (cfg_we) begin
            keep_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == REG_KEEP_MS) ? keep_reg : '0;

    pfrm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pfrm_datapath #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .MAX_ENTRIES  (MAX_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_func       (s_tuser),
        .in_len        (s_tdata[19:0]),
        .in_ms         (s_tdata[51:20]),
        .keep_ms       (keep_reg),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_accepted  (out_acc),
        .out_offset    (out_off),
        .out_entry_len (out_len),
        .out_entry_ms  (out_ms),
        .out_dropped   (out_drop),
        .out_count     (out_cnt)
    );

    // result beat packing
    assign m_tdata = {out_cnt, out_drop, out_ms, out_len, out_off};
    assign m_tuser = out_acc;

endmodule
